// File: rtl/core/hsvrgb_pkg.sv
// Shared widths, fixed-point constants and the hue sector type for the
// HSV to RGB converter. No dependencies; every other file imports it.
package hsvrgb_pkg;

	localparam int LEVEL_FRACTION_BITS = 12;
	localparam int HUE_FRACTION_BITS   = 4;

	localparam int HUE_W   = 16;
	localparam int LEVEL_W = LEVEL_FRACTION_BITS + 1;
	localparam int MAG_W   = HUE_W + 1;

	localparam logic [LEVEL_W-1:0] LEVEL_ONE = LEVEL_W'(1) << LEVEL_FRACTION_BITS;

	// Sixty degrees in hue units, written as 15 * 2^SIXTY_SHIFT.
	localparam int SIXTY_SHIFT = HUE_FRACTION_BITS + 2;
	localparam int HUE_SIXTY   = 60 << HUE_FRACTION_BITS;

	// floor(n / 15) = (n * RECIP15) >> RECIP_SHIFT, exact for n below 74898.
	localparam int RECIP_SHIFT = 20;
	localparam int RECIP_W     = 17;
	localparam logic [RECIP_W-1:0] RECIP15 = RECIP_W'(((1 << RECIP_SHIFT) + 14) / 15);

	// Whole sixty-degree steps in |hue|, and the width of a remainder.
	localparam int STEP_W = 6;
	localparam int FRAC_W = 10;

	typedef enum logic [2:0] {
		SEC_RED_YELLOW    = 3'd0,
		SEC_YELLOW_GREEN  = 3'd1,
		SEC_GREEN_CYAN    = 3'd2,
		SEC_CYAN_BLUE     = 3'd3,
		SEC_BLUE_MAGENTA  = 3'd4,
		SEC_MAGENTA_RED   = 3'd5
	} sector_t;

endpackage

// File: rtl/core/hsvrgb_if.sv
// Valid/ready channel interfaces for HSV pixels in and RGB pixels out.
// Depends on hsvrgb_pkg for the field widths.
interface hsvrgb_hsv_if
	import hsvrgb_pkg::*;
();
	logic               valid;
	logic               ready;
	logic [HUE_W-1:0]   hue;
	logic [LEVEL_W-1:0] saturation;
	logic [LEVEL_W-1:0] brightness;

	modport source (output valid, output hue, output saturation, output brightness,
		input ready);
	modport sink (input valid, input hue, input saturation, input brightness,
		output ready);
endinterface

interface hsvrgb_rgb_if
	import hsvrgb_pkg::*;
();
	logic               valid;
	logic               ready;
	logic [LEVEL_W-1:0] red_level;
	logic [LEVEL_W-1:0] green_level;
	logic [LEVEL_W-1:0] blue_level;

	modport source (output valid, output red_level, output green_level,
		output blue_level, input ready);
	modport sink (input valid, input red_level, input green_level,
		input blue_level, output ready);
endinterface

// File: rtl/core/hsv_to_rgb_converter.sv
// Top level of the HSV to RGB converter: a six-stage pipeline.
// Depends on hsvrgb_pkg and the channel interfaces in hsvrgb_if.sv.
//
// The converter takes one pixel per clock while hsv.ready is high. Each
// pipeline stage holds its item until the next stage can take it, so a
// stall at the output fills the bubbles first and stops the input only
// when all six stages are full. The stages in order: hue magnitude, chroma
// with the hue step split, remainder and sector, X multiply with the shift
// part of the division by sixty, division by fifteen, and sector placement.
module hsv_to_rgb_converter
	import hsvrgb_pkg::*;
(
	input  logic          clk,
	input  logic          arst_n,
	hsvrgb_hsv_if.sink    hsv,
	hsvrgb_rgb_if.source  rgb
);

	localparam int NSTAGE = 6;

	function automatic logic [LEVEL_W-1:0] clamp_level(input logic [LEVEL_W-1:0] raw);
		return (raw > LEVEL_ONE) ? LEVEL_ONE : raw;
	endfunction

	logic [NSTAGE:1] vld;
	logic [NSTAGE:1] adv;

	// A stage loads when it is empty or when the stage after it loads; the last stage loads when rgb.ready is high.
	always_comb begin
		adv[NSTAGE] = ~vld[NSTAGE] | rgb.ready;
		for (int k = NSTAGE - 1; k >= 1; k--) begin
			adv[k] = ~vld[k] | adv[k+1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld <= '0;
		end else begin
			if (adv[1]) begin
				vld[1] <= hsv.valid;
			end
			for (int k = 2; k <= NSTAGE; k++) begin
				if (adv[k]) begin
					vld[k] <= vld[k-1];
				end
			end
		end
	end

	assign hsv.ready = adv[1];
	assign rgb.valid = vld[NSTAGE];

	// Stage 1: hue magnitude and clamped levels.
	logic [MAG_W-1:0]   mag_s1;
	logic [LEVEL_W-1:0] sat_s1;
	logic [LEVEL_W-1:0] val_s1;

	always_ff @(posedge clk) begin
		if (adv[1]) begin
			mag_s1 <= hsv.hue[HUE_W-1] ? (MAG_W'(1) << HUE_W) - {1'b0, hsv.hue}
				: {1'b0, hsv.hue};
			sat_s1 <= clamp_level(hsv.saturation);
			val_s1 <= clamp_level(hsv.brightness);
		end
	end

	// Stage 2: chroma and the number of whole sixty-degree steps in |hue|.
	logic [2*LEVEL_W-1:0]                   vs_prod;
	logic [MAG_W-SIXTY_SHIFT-1:0]           mag_hi;
	logic [MAG_W-SIXTY_SHIFT+RECIP_W-1:0]   step_prod;
	logic [LEVEL_W-1:0]                     c_s2;
	logic [LEVEL_W-1:0]                     val_s2;
	logic [MAG_W-1:0]                       mag_s2;
	logic [STEP_W-1:0]                      step_s2;

	assign vs_prod   = val_s1 * sat_s1;
	assign mag_hi    = mag_s1[MAG_W-1:SIXTY_SHIFT];
	assign step_prod = mag_hi * RECIP15;

	always_ff @(posedge clk) begin
		if (adv[2]) begin
			c_s2    <= vs_prod[LEVEL_FRACTION_BITS +: LEVEL_W];
			val_s2  <= val_s1;
			mag_s2  <= mag_s1;
			step_s2 <= step_prod[RECIP_SHIFT +: STEP_W];
		end
	end

	// Stage 3: remainder within the step, X weight, sector and m.
	// The step count stays below 35, where (q * 11) >> 6 equals q / 6.
	logic [MAG_W-1:0]    step_base;
	logic [FRAC_W-1:0]   frac;
	logic [2*STEP_W-1:0] turn_prod;
	logic [STEP_W-1:0]   turns;
	logic [STEP_W-1:0]   sec_raw;
	logic [LEVEL_W-1:0]  c_s3;
	logic [LEVEL_W-1:0]  m_s3;
	logic [FRAC_W-1:0]   w_s3;
	sector_t             sec_s3;

	assign step_base = MAG_W'(step_s2) * MAG_W'(HUE_SIXTY);
	assign frac      = FRAC_W'(mag_s2 - step_base);
	assign turn_prod = (2 * STEP_W)'(step_s2) * (2 * STEP_W)'(11);
	assign turns     = turn_prod[STEP_W +: STEP_W];
	assign sec_raw   = step_s2 - STEP_W'(turns * STEP_W'(6));

	always_ff @(posedge clk) begin
		if (adv[3]) begin
			c_s3   <= c_s2;
			m_s3   <= val_s2 - c_s2;
			// X rises through even sectors and falls through odd ones.
			w_s3   <= step_s2[0] ? FRAC_W'(HUE_SIXTY) - frac : frac;
			sec_s3 <= sector_t'(sec_raw[2:0]);
		end
	end

	// Stage 4: C times the weight, divided by the power-of-two part of sixty.
	logic [LEVEL_W+FRAC_W-1:0]         cw_prod;
	logic [LEVEL_W+FRAC_W-SIXTY_SHIFT-1:0] n_s4;
	logic [LEVEL_W-1:0]                c_s4;
	logic [LEVEL_W-1:0]                m_s4;
	sector_t                           sec_s4;

	assign cw_prod = c_s3 * w_s3;

	always_ff @(posedge clk) begin
		if (adv[4]) begin
			n_s4   <= cw_prod[LEVEL_W+FRAC_W-1:SIXTY_SHIFT];
			c_s4   <= c_s3;
			m_s4   <= m_s3;
			sec_s4 <= sec_s3;
		end
	end

	// Stage 5: the remaining division by fifteen.
	logic [LEVEL_W+FRAC_W-SIXTY_SHIFT+RECIP_W-1:0] x_prod;
	logic [LEVEL_W-1:0] x_s5;
	logic [LEVEL_W-1:0] c_s5;
	logic [LEVEL_W-1:0] m_s5;
	sector_t            sec_s5;

	assign x_prod = n_s4 * RECIP15;

	always_ff @(posedge clk) begin
		if (adv[5]) begin
			x_s5   <= x_prod[RECIP_SHIFT +: LEVEL_W];
			c_s5   <= c_s4;
			m_s5   <= m_s4;
			sec_s5 <= sec_s4;
		end
	end

	// Stage 6: place C, X and zero by sector and add m.
	logic [LEVEL_W-1:0] r_pre;
	logic [LEVEL_W-1:0] g_pre;
	logic [LEVEL_W-1:0] b_pre;
	logic [LEVEL_W-1:0] red_s6;
	logic [LEVEL_W-1:0] green_s6;
	logic [LEVEL_W-1:0] blue_s6;

	always_comb begin
		unique case (sec_s5)
			SEC_RED_YELLOW: begin
				r_pre = c_s5; g_pre = x_s5; b_pre = '0;
			end
			SEC_YELLOW_GREEN: begin
				r_pre = x_s5; g_pre = c_s5; b_pre = '0;
			end
			SEC_GREEN_CYAN: begin
				r_pre = '0; g_pre = c_s5; b_pre = x_s5;
			end
			SEC_CYAN_BLUE: begin
				r_pre = '0; g_pre = x_s5; b_pre = c_s5;
			end
			SEC_BLUE_MAGENTA: begin
				r_pre = x_s5; g_pre = '0; b_pre = c_s5;
			end
			default: begin
				r_pre = c_s5; g_pre = '0; b_pre = x_s5;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (adv[6]) begin
			red_s6   <= r_pre + m_s5;
			green_s6 <= g_pre + m_s5;
			blue_s6  <= b_pre + m_s5;
		end
	end

	assign rgb.red_level   = red_s6;
	assign rgb.green_level = green_s6;
	assign rgb.blue_level  = blue_s6;

endmodule
